[hw/rtl/midi_track_event_parser_assert.svh]
// assertion macros for the midi track event parser
// used by midi_track_event_parser.sv; expects signals named clock and reset in scope
`ifndef MIDI_TRACK_EVENT_PARSER_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MTEP_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("midi track event parser: implication check failed");

// next-cycle implication, checked outside reset
`define MTEP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("midi track event parser: next-cycle check failed");

`endif

[hw/rtl/mtep_pkg.sv]
// types, codes and helpers for the midi track event parser
// no dependencies; imported by midi_track_event_parser

package mtep_pkg;

   localparam int DEFAULT_TICK_BITS = 32;
   localparam int OUT_DEPTH         = 4;

   localparam logic [7:0] ST_META   = 8'hFF;
   localparam logic [7:0] ST_SYSEX  = 8'hF0;
   localparam logic [7:0] ST_ESCAPE = 8'hF7;
   localparam logic [3:0] CLS_SYS   = 4'hF;
   localparam logic [3:0] CLS_OFF   = 4'h8;
   localparam logic [3:0] CLS_ON    = 4'h9;
   localparam logic [3:0] CLS_CTRL  = 4'hB;
   localparam logic [3:0] CLS_PROG  = 4'hC;
   localparam logic [3:0] CLS_PRESS = 4'hD;

   localparam logic [7:0]  META_TEMPO = 8'h51;
   localparam logic [7:0]  META_END   = 8'h2F;
   localparam logic [27:0] TEMPO_LEN  = 28'd3;
   localparam logic [2:0]  VLQ_MAX    = 3'd4;

   typedef enum logic [3:0] {
      PH_DELTA,
      PH_STATUS,
      PH_DATA1,
      PH_DATA2,
      PH_META_TYPE,
      PH_META_LEN,
      PH_META_BODY,
      PH_SYSEX_LEN,
      PH_SYSEX_SKIP
   } phase_type;

   typedef enum logic [2:0] {
      KIND_ON,
      KIND_OFF,
      KIND_CTRL,
      KIND_PROG,
      KIND_TEMPO,
      KIND_END,
      KIND_ERROR
   } kind_type;

   typedef struct packed {
      logic        vld;
      kind_type    kind;
      logic [3:0]  channel;
      logic [7:0]  d1;
      logic [7:0]  d2;
   } event_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  channel;
      logic [7:0]  d1;
      logic [7:0]  d2;
      logic [23:0] tempo;
      logic [31:0] tick;
      logic        run_end;
   } result_type;

   // statuses that carry a single data byte
   function automatic logic one_byte(input logic [7:0] status);
      return (status[7:4] == CLS_PROG) || (status[7:4] == CLS_PRESS);
   endfunction

   // channel message completed: what, if anything, gets reported
   function automatic event_type channel_event(input logic [7:0] status,
                                               input logic [7:0] d1,
                                               input logic [7:0] d2);
      event_type e;
      e.vld     = 1'b1;
      e.kind    = KIND_OFF;
      e.channel = status[3:0];
      e.d1      = d1;
      e.d2      = d2;
      if (status[7:4] == CLS_OFF || (status[7:4] == CLS_ON && d2 == 8'd0)) begin
         e.kind = KIND_OFF;
      end else if (status[7:4] == CLS_ON) begin
         e.kind = KIND_ON;
      end else if (status[7:4] == CLS_CTRL) begin
         e.kind = KIND_CTRL;
      end else if (status[7:4] == CLS_PROG) begin
         e.kind = KIND_PROG;
         e.d2   = 8'd0;
      end else begin
         e.vld = 1'b0;
      end
      return e;
   endfunction

endpackage

[hw/rtl/midi_track_event_parser.sv]
// midi track event parser: byte-wise smf track decoding with a small result queue
// depends on mtep_pkg and midi_track_event_parser_assert.svh
//
// usage:
//   req channel: one track byte per transaction in req_tdata, req_tlast on the
//   final byte of the chunk. rsp channel: one decoded event per transaction,
//   event kind in rsp_tuser, rsp_tlast on the last event caused by a byte.
//   each byte is decoded in the cycle it is accepted and its events (none, one,
//   or two on the final byte) are written into a four-entry result queue that
//   drives rsp from its registered entries.
//   throughput is one byte per cycle while req_tready is high; the queue drains
//   one event per cycle while rsp_tready is high, so a byte that yields two
//   events needs two rsp transactions. req_tready is high while the queue has
//   room for two events; when the receiver stalls, bytes are still taken until
//   at least three events wait, then req_tready drops. nothing is lost or dropped.
//   the final byte returns the parser state to its reset values.
//   reset (synchronous, active high) clears the parser state and empties the
//   queue; the block takes bytes as soon as reset is released.

module midi_track_event_parser
   import mtep_pkg::*;
#(
   parameter int TICK_BITS = DEFAULT_TICK_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // track_byte
   input  logic        req_tlast,   // chunk_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // event_channel, first_data, second_data,
                                    // tempo_value, tick_time, zero pad
   output logic [2:0]  rsp_tuser,   // event_kind
   output logic        rsp_tlast    // run_end
);

   `include "midi_track_event_parser_assert.svh"

   localparam int ACC_W = (TICK_BITS < 32) ? TICK_BITS : 32;
   localparam logic [32:0] TICK_LIMIT = (33'd1 << ACC_W) - 33'd1;
   localparam int PTR_W = $clog2(OUT_DEPTH);
   localparam int CNT_W = $clog2(OUT_DEPTH + 1);

   // parser state
   phase_type          phase_ff, phase_in, phase_fd;
   logic [ACC_W-1:0]   acc_ff, acc_in, acc_fd;
   logic [7:0]         running_ff, running_in, running_fd;
   logic [7:0]         cur_ff, cur_in, cur_fd;
   logic [27:0]        vlq_ff, vlq_in, vlq_fd;
   logic [2:0]         vcnt_ff, vcnt_in, vcnt_fd;
   logic [7:0]         held_ff, held_in, held_fd;
   logic [7:0]         meta_ff, meta_in, meta_fd;
   logic [27:0]        skip_ff, skip_in, skip_fd;
   logic [23:0]        tempo_ff, tempo_in, tempo_fd;
   logic               end_ff, end_in, end_fd;
   logic               err_ff, err_in, err_fd;

   // result queue
   result_type         queue_ff [OUT_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic               accept, pop;
   logic [7:0]         b;
   logic [27:0]        vlq_shift, skip_dec;
   logic [2:0]         vcnt_inc;
   logic               vlq_long;
   logic [32:0]        tick_sum;
   logic [ACC_W-1:0]   acc_sat;
   logic [23:0]        tempo_nx;
   event_type          first_evt, data2_evt;
   logic               f_vld, l_vld, l_error;
   kind_type           f_kind;
   logic [3:0]         f_channel;
   logic [7:0]         f_d1, f_d2;
   logic [23:0]        f_tempo;
   result_type         res_a, res_b;
   logic [1:0]         n_push;

   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;
   assign b      = req_tdata;

   // shared decode
   assign vlq_shift = {vlq_ff[20:0], b[6:0]};
   assign vcnt_inc  = vcnt_ff + 3'd1;
   assign vlq_long  = b[7] && (vcnt_inc >= VLQ_MAX);
   assign tick_sum  = 33'(acc_ff) + 33'(vlq_shift);
   assign acc_sat   = (tick_sum > TICK_LIMIT) ? TICK_LIMIT[ACC_W-1:0] : tick_sum[ACC_W-1:0];
   assign tempo_nx  = {tempo_ff[15:0], b};
   assign skip_dec  = skip_ff - 28'd1;
   assign first_evt = channel_event((phase_ff == PH_STATUS) ? running_ff : cur_ff, b, 8'd0);
   assign data2_evt = channel_event(cur_ff, held_ff, b);

   // next state after feeding one byte
   always_comb begin
      phase_fd   = phase_ff;
      acc_fd     = acc_ff;
      running_fd = running_ff;
      cur_fd     = cur_ff;
      vlq_fd     = vlq_ff;
      vcnt_fd    = vcnt_ff;
      held_fd    = held_ff;
      meta_fd    = meta_ff;
      skip_fd    = skip_ff;
      tempo_fd   = tempo_ff;
      end_fd     = end_ff;
      err_fd     = err_ff;
      if (!err_ff) begin
         unique case (phase_ff)
            PH_DELTA: begin
               vlq_fd  = vlq_shift;
               vcnt_fd = vcnt_inc;
               if (!b[7]) begin
                  acc_fd   = acc_sat;
                  vlq_fd   = '0;
                  vcnt_fd  = '0;
                  phase_fd = PH_STATUS;
               end else if (vlq_long) begin
                  err_fd = 1'b1;
               end
            end
            PH_STATUS: begin
               if (!b[7]) begin
                  if (running_ff == 8'd0) begin
                     err_fd = 1'b1;
                  end else begin
                     cur_fd  = running_ff;
                     held_fd = b;
                     if (one_byte(running_ff)) begin
                        phase_fd = PH_DELTA;
                        vlq_fd   = '0;
                        vcnt_fd  = '0;
                     end else begin
                        phase_fd = PH_DATA2;
                     end
                  end
               end else begin
                  cur_fd     = b;
                  running_fd = (b[7:4] == CLS_SYS) ? 8'd0 : b;
                  if (b == ST_META) begin
                     phase_fd = PH_META_TYPE;
                  end else if (b == ST_SYSEX || b == ST_ESCAPE) begin
                     vlq_fd   = '0;
                     vcnt_fd  = '0;
                     phase_fd = PH_SYSEX_LEN;
                  end else if (b[7:4] == CLS_SYS) begin
                     err_fd = 1'b1;
                  end else begin
                     phase_fd = PH_DATA1;
                  end
               end
            end
            PH_DATA1: begin
               held_fd = b;
               if (one_byte(cur_ff)) begin
                  phase_fd = PH_DELTA;
                  vlq_fd   = '0;
                  vcnt_fd  = '0;
               end else begin
                  phase_fd = PH_DATA2;
               end
            end
            PH_DATA2: begin
               phase_fd = PH_DELTA;
               vlq_fd   = '0;
               vcnt_fd  = '0;
            end
            PH_META_TYPE: begin
               meta_fd  = b;
               vlq_fd   = '0;
               vcnt_fd  = '0;
               phase_fd = PH_META_LEN;
            end
            PH_META_LEN: begin
               vlq_fd  = vlq_shift;
               vcnt_fd = vcnt_inc;
               if (!b[7]) begin
                  vcnt_fd  = '0;
                  skip_fd  = vlq_shift;
                  tempo_fd = '0;
                  if (vlq_shift == 28'd0) begin
                     // empty body: meta event ends here
                     if (meta_ff == META_END) begin
                        end_fd = 1'b1;
                     end
                     phase_fd = PH_DELTA;
                     vlq_fd   = '0;
                  end else begin
                     phase_fd = PH_META_BODY;
                  end
               end else if (vlq_long) begin
                  err_fd = 1'b1;
               end
            end
            PH_META_BODY: begin
               tempo_fd = tempo_nx;
               skip_fd  = skip_dec;
               if (skip_dec == 28'd0) begin
                  if (meta_ff == META_END) begin
                     end_fd = 1'b1;
                  end
                  phase_fd = PH_DELTA;
                  vlq_fd   = '0;
                  vcnt_fd  = '0;
               end
            end
            PH_SYSEX_LEN: begin
               vlq_fd  = vlq_shift;
               vcnt_fd = vcnt_inc;
               if (!b[7]) begin
                  skip_fd = vlq_shift;
                  if (vlq_shift == 28'd0) begin
                     phase_fd = PH_DELTA;
                     vlq_fd   = '0;
                     vcnt_fd  = '0;
                  end else begin
                     phase_fd = PH_SYSEX_SKIP;
                  end
               end else if (vlq_long) begin
                  err_fd = 1'b1;
               end
            end
            PH_SYSEX_SKIP: begin
               skip_fd = skip_dec;
               if (skip_dec == 28'd0) begin
                  phase_fd = PH_DELTA;
                  vlq_fd   = '0;
                  vcnt_fd  = '0;
               end
            end
            default: begin
               phase_fd = PH_DELTA;
               vlq_fd   = '0;
               vcnt_fd  = '0;
            end
         endcase
      end
   end

   // the final byte of a chunk puts everything back to reset values
   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      running_in = running_ff;
      cur_in     = cur_ff;
      vlq_in     = vlq_ff;
      vcnt_in    = vcnt_ff;
      held_in    = held_ff;
      meta_in    = meta_ff;
      skip_in    = skip_ff;
      tempo_in   = tempo_ff;
      end_in     = end_ff;
      err_in     = err_ff;
      if (accept) begin
         if (req_tlast) begin
            phase_in   = PH_DELTA;
            acc_in     = '0;
            running_in = '0;
            cur_in     = '0;
            vlq_in     = '0;
            vcnt_in    = '0;
            held_in    = '0;
            meta_in    = '0;
            skip_in    = '0;
            tempo_in   = '0;
            end_in     = 1'b0;
            err_in     = 1'b0;
         end else begin
            phase_in   = phase_fd;
            acc_in     = acc_fd;
            running_in = running_fd;
            cur_in     = cur_fd;
            vlq_in     = vlq_fd;
            vcnt_in    = vcnt_fd;
            held_in    = held_fd;
            meta_in    = meta_fd;
            skip_in    = skip_fd;
            tempo_in   = tempo_fd;
            end_in     = end_fd;
            err_in     = err_fd;
         end
      end
   end

   // event caused by feeding the byte
   always_comb begin
      f_vld     = 1'b0;
      f_kind    = KIND_ERROR;
      f_channel = '0;
      f_d1      = '0;
      f_d2      = '0;
      f_tempo   = '0;
      if (!err_ff) begin
         unique case (phase_ff) inside
            PH_DELTA, PH_SYSEX_LEN: begin
               f_vld = vlq_long;
            end
            PH_STATUS: begin
               if (!b[7]) begin
                  if (running_ff == 8'd0) begin
                     f_vld = 1'b1;
                  end else if (one_byte(running_ff)) begin
                     f_vld     = first_evt.vld;
                     f_kind    = first_evt.kind;
                     f_channel = first_evt.channel;
                     f_d1      = first_evt.d1;
                     f_d2      = first_evt.d2;
                  end
               end else begin
                  f_vld = (b[7:4] == CLS_SYS) && (b != ST_META) && (b != ST_SYSEX)
                          && (b != ST_ESCAPE);
               end
            end
            PH_DATA1: begin
               if (one_byte(cur_ff)) begin
                  f_vld     = first_evt.vld;
                  f_kind    = first_evt.kind;
                  f_channel = first_evt.channel;
                  f_d1      = first_evt.d1;
                  f_d2      = first_evt.d2;
               end
            end
            PH_DATA2: begin
               f_vld     = data2_evt.vld;
               f_kind    = data2_evt.kind;
               f_channel = data2_evt.channel;
               f_d1      = data2_evt.d1;
               f_d2      = data2_evt.d2;
            end
            PH_META_LEN: begin
               if (!b[7]) begin
                  // tempo needs a three-byte body, so only end of track fits here
                  if (vlq_shift == 28'd0 && meta_ff == META_END) begin
                     f_vld  = 1'b1;
                     f_kind = KIND_END;
                  end
               end else begin
                  f_vld = vlq_long;
               end
            end
            PH_META_BODY: begin
               if (skip_dec == 28'd0) begin
                  if (meta_ff == META_TEMPO && vlq_ff == TEMPO_LEN) begin
                     f_vld   = 1'b1;
                     f_kind  = KIND_TEMPO;
                     f_tempo = tempo_nx;
                  end else if (meta_ff == META_END) begin
                     f_vld  = 1'b1;
                     f_kind = KIND_END;
                  end
               end
            end
            default: begin
               f_vld = 1'b0;
            end
         endcase
      end
   end

   // closing event on the final byte: truncation error or added end of track
   assign l_error = (phase_fd != PH_DELTA) || (vcnt_fd != 3'd0);
   assign l_vld   = req_tlast && !err_fd && (l_error || !end_fd);

   always_comb begin
      res_b.kind    = l_error ? KIND_ERROR : KIND_END;
      res_b.channel = '0;
      res_b.d1      = '0;
      res_b.d2      = '0;
      res_b.tempo   = '0;
      res_b.tick    = 32'(acc_fd);
      res_b.run_end = 1'b1;
      if (f_vld) begin
         res_a.kind    = f_kind;
         res_a.channel = f_channel;
         res_a.d1      = f_d1;
         res_a.d2      = f_d2;
         res_a.tempo   = f_tempo;
         res_a.tick    = 32'(acc_fd);
         res_a.run_end = !l_vld;
      end else begin
         res_a = res_b;
      end
      if (!accept) begin
         n_push = 2'd0;
      end else begin
         n_push = 2'(f_vld) + 2'(l_vld);
      end
   end

   // queue pointers and fill count
   always_comb begin
      wr_in  = wr_ff + PTR_W'(n_push);
      rd_in  = rd_ff + PTR_W'(pop);
      cnt_in = cnt_ff + CNT_W'(n_push) - CNT_W'(pop);
   end

   assign req_tready = cnt_ff <= CNT_W'(OUT_DEPTH - 2);
   assign rsp_tvalid = cnt_ff != '0;
   assign rsp_tuser  = queue_ff[rd_ff].kind;
   assign rsp_tlast  = queue_ff[rd_ff].run_end;
   assign rsp_tdata  = {4'd0, queue_ff[rd_ff].tick, queue_ff[rd_ff].tempo,
                        queue_ff[rd_ff].d2, queue_ff[rd_ff].d1, queue_ff[rd_ff].channel};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_DELTA;
         acc_ff     <= '0;
         running_ff <= '0;
         cur_ff     <= '0;
         vlq_ff     <= '0;
         vcnt_ff    <= '0;
         held_ff    <= '0;
         meta_ff    <= '0;
         skip_ff    <= '0;
         tempo_ff   <= '0;
         end_ff     <= 1'b0;
         err_ff     <= 1'b0;
         wr_ff      <= '0;
         rd_ff      <= '0;
         cnt_ff     <= '0;
      end else begin
         phase_ff   <= phase_in;
         acc_ff     <= acc_in;
         running_ff <= running_in;
         cur_ff     <= cur_in;
         vlq_ff     <= vlq_in;
         vcnt_ff    <= vcnt_in;
         held_ff    <= held_in;
         meta_ff    <= meta_in;
         skip_ff    <= skip_in;
         tempo_ff   <= tempo_in;
         end_ff     <= end_in;
         err_ff     <= err_in;
         wr_ff      <= wr_in;
         rd_ff      <= rd_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         queue_ff[wr_ff] <= res_a;
      end
      if (n_push == 2'd2) begin
         queue_ff[wr_ff + PTR_W'(1)] <= res_b;
      end
   end

   // a result that is not the last of its byte always has its partner queued
   `MTEP_ASSERT_IMP(a_pair_queued, rsp_tvalid && !rsp_tlast, cnt_ff >= CNT_W'(2))
   // once an error is held, bytes give no results
   `MTEP_ASSERT_IMP(a_error_silent, accept && err_ff, n_push == 2'd0)
   // the final byte leaves the parser in its reset state
   `MTEP_ASSERT_NEXT(a_last_resets, accept && req_tlast,
                     phase_ff == PH_DELTA && acc_ff == '0 && !err_ff && !end_ff)

endmodule

[test/midi_track_event_parser_test.sv]
// self-checking bench for midi_track_event_parser: directed and random track chunks
// are streamed in over req_*, decoded events are predicted and compared on rsp_*
// depends on mtep_pkg and the parser rtl only

module midi_track_event_parser_test
   import mtep_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          TICK_W       = DEFAULT_TICK_BITS;
   localparam logic [32:0] TICK_MAX     = (TICK_W >= 32) ? 33'h0FFFFFFFF
                                                         : (33'd1 << TICK_W) - 33'd1;
   localparam int          RANDOM_BYTES = 1000;
   localparam int          STALL_LIMIT  = 3000;
   localparam int          SETTLE       = 8;
   localparam logic [3:0]  CLS_TOUCH    = 4'hA;
   localparam logic [3:0]  CLS_BEND     = 4'hE;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;    // track_byte
   logic        req_tlast = 1'b0;    // chunk_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;           // event_channel, first_data, second_data,
                                     // tempo_value, tick_time, zero pad
   logic [2:0]  rsp_tuser;           // event_kind
   logic        rsp_tlast;           // run_end

   midi_track_event_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser state as predicted
   phase_type   ph;
   logic [31:0] tick_acc;
   logic [7:0]  run_status;
   logic [7:0]  cur_status;
   logic [27:0] vlq_val;
   logic [2:0]  vlq_cnt;
   logic [7:0]  held;
   logic [7:0]  meta_code;
   logic [27:0] skip_left;
   logic [23:0] tempo_acc;
   logic        end_flag;
   logic        err_flag;

   result_type  byte_events[$];
   result_type  expected_events[$];
   logic [7:0]  trk[$];

   logic        quiet = 1'b0;
   int unsigned stall_left = 0;
   int          faults = 0;
   int          shown = 0;
   int          bytes_sent = 0;
   int          live_bytes = 0;
   int          chunks_sent = 0;
   int          kind_count[7];

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // ---------------------------------------------------------------- predictor

   function automatic void clear_parser();
      ph         = PH_DELTA;
      tick_acc   = 32'd0;
      run_status = 8'd0;
      cur_status = 8'd0;
      vlq_val    = 28'd0;
      vlq_cnt    = 3'd0;
      held       = 8'd0;
      meta_code  = 8'd0;
      skip_left  = 28'd0;
      tempo_acc  = 24'd0;
      end_flag   = 1'b0;
      err_flag   = 1'b0;
   endfunction

   function automatic void emit(input kind_type k, input logic [3:0] ch,
                                input logic [7:0] d1, input logic [7:0] d2,
                                input logic [23:0] tempo);
      result_type r;
      r.kind    = k;
      r.channel = ch;
      r.d1      = d1;
      r.d2      = d2;
      r.tempo   = tempo;
      r.tick    = tick_acc;
      r.run_end = 1'b0;
      byte_events.push_back(r);
   endfunction

   function automatic void raise_fault();
      emit(KIND_ERROR, 4'd0, 8'd0, 8'd0, 24'd0);
      err_flag = 1'b1;
   endfunction

   function automatic void back_to_delta();
      ph      = PH_DELTA;
      vlq_val = 28'd0;
      vlq_cnt = 3'd0;
   endfunction

   // 1 when the quantity is complete, 0 for more bytes, -1 when too long
   function automatic int vlq_step(input logic [7:0] b);
      vlq_val = {vlq_val[20:0], b[6:0]};
      vlq_cnt = vlq_cnt + 3'd1;
      if (!b[7]) return 1;
      if (vlq_cnt >= VLQ_MAX) return -1;
      return 0;
   endfunction

   function automatic void finish_channel(input logic [7:0] d2);
      case (cur_status[7:4])
         CLS_OFF:  emit(KIND_OFF, cur_status[3:0], held, d2, 24'd0);
         CLS_ON:   emit((d2 == 8'd0) ? KIND_OFF : KIND_ON, cur_status[3:0], held, d2, 24'd0);
         CLS_CTRL: emit(KIND_CTRL, cur_status[3:0], held, d2, 24'd0);
         CLS_PROG: emit(KIND_PROG, cur_status[3:0], held, 8'd0, 24'd0);
         default: ;
      endcase
      back_to_delta();
   endfunction

   function automatic void take_first(input logic [7:0] b);
      held = b;
      if (cur_status[7:4] == CLS_PROG || cur_status[7:4] == CLS_PRESS) begin
         finish_channel(8'd0);
      end else begin
         ph = PH_DATA2;
      end
   endfunction

   function automatic void finish_meta();
      if (meta_code == META_TEMPO && vlq_val == TEMPO_LEN) begin
         emit(KIND_TEMPO, 4'd0, 8'd0, 8'd0, tempo_acc);
      end else if (meta_code == META_END) begin
         emit(KIND_END, 4'd0, 8'd0, 8'd0, 24'd0);
         end_flag = 1'b1;
      end
      back_to_delta();
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic last);
      int          step;
      logic [32:0] sum;
      result_type  r;
      byte_events.delete();
      if (!err_flag) begin
         case (ph)
            PH_DELTA: begin
               step = vlq_step(b);
               if (step < 0) begin
                  raise_fault();
               end else if (step > 0) begin
                  sum      = {1'b0, tick_acc} + {5'd0, vlq_val};
                  tick_acc = (sum > TICK_MAX) ? TICK_MAX[31:0] : sum[31:0];
                  vlq_val  = 28'd0;
                  vlq_cnt  = 3'd0;
                  ph       = PH_STATUS;
               end
            end
            PH_STATUS: begin
               if (!b[7]) begin
                  if (run_status == 8'd0) begin
                     raise_fault();
                  end else begin
                     cur_status = run_status;
                     take_first(b);
                  end
               end else begin
                  cur_status = b;
                  // system statuses cancel running status
                  run_status = (b[7:4] == CLS_SYS) ? 8'd0 : b;
                  if (b == ST_META) begin
                     ph = PH_META_TYPE;
                  end else if (b == ST_SYSEX || b == ST_ESCAPE) begin
                     vlq_val = 28'd0;
                     vlq_cnt = 3'd0;
                     ph      = PH_SYSEX_LEN;
                  end else if (b[7:4] == CLS_SYS) begin
                     raise_fault();
                  end else begin
                     ph = PH_DATA1;
                  end
               end
            end
            PH_DATA1: take_first(b);
            PH_DATA2: finish_channel(b);
            PH_META_TYPE: begin
               meta_code = b;
               vlq_val   = 28'd0;
               vlq_cnt   = 3'd0;
               ph        = PH_META_LEN;
            end
            PH_META_LEN: begin
               step = vlq_step(b);
               if (step < 0) begin
                  raise_fault();
               end else if (step > 0) begin
                  vlq_cnt   = 3'd0;
                  skip_left = vlq_val;
                  tempo_acc = 24'd0;
                  if (skip_left == 28'd0) finish_meta();
                  else ph = PH_META_BODY;
               end
            end
            PH_META_BODY: begin
               tempo_acc = {tempo_acc[15:0], b};
               skip_left = skip_left - 28'd1;
               if (skip_left == 28'd0) finish_meta();
            end
            PH_SYSEX_LEN: begin
               step = vlq_step(b);
               if (step < 0) begin
                  raise_fault();
               end else if (step > 0) begin
                  skip_left = vlq_val;
                  if (skip_left == 28'd0) back_to_delta();
                  else ph = PH_SYSEX_SKIP;
               end
            end
            PH_SYSEX_SKIP: begin
               skip_left = skip_left - 28'd1;
               if (skip_left == 28'd0) back_to_delta();
            end
            default: back_to_delta();
         endcase
      end
      if (last) begin
         if (!err_flag) begin
            // an unfinished event, even a partial delta, is a truncation
            if (ph != PH_DELTA || vlq_cnt != 3'd0) raise_fault();
            else if (!end_flag) emit(KIND_END, 4'd0, 8'd0, 8'd0, 24'd0);
         end
         clear_parser();
      end
      for (int i = 0; i < byte_events.size(); i++) begin
         r         = byte_events[i];
         r.run_end = (i == byte_events.size() - 1);
         expected_events.push_back(r);
      end
   endfunction

   // ---------------------------------------------------------------- stimulus

   task automatic send_byte(input logic [7:0] b, input logic last);
      int unsigned gap;
      gap = quiet ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      if (!err_flag) live_bytes++;
      decode_byte(b, last);
   endtask

   task automatic send_chunk();
      for (int i = 0; i < trk.size(); i++) send_byte(trk[i], i == trk.size() - 1);
      trk.delete();
      chunks_sent++;
   endtask

   // sender holds off until every predicted event has been seen
   task automatic drain_events();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_events.size() != 0);
   endtask

   function automatic logic [7:0] data_byte();
      if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 127));
   endfunction

   function automatic void put_vlq(input logic [27:0] v);
      int nb;
      nb = (v < 28'd128) ? 1 : (v < 28'd16384) ? 2 : (v < 28'd2097152) ? 3 : 4;
      if (nb < 4 && $urandom_range(0, 9) == 0) nb++;   // redundant leading group
      for (int i = nb - 1; i >= 0; i--) trk.push_back({i != 0, 7'(v >> (7 * i))});
   endfunction

   function automatic void put_body(input int len);
      for (int i = 0; i < len; i++) trk.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void put_meta(input logic [7:0] mtype, input int len);
      trk.push_back(ST_META);
      trk.push_back(mtype);
      put_vlq(28'(len));
      put_body(len);
   endfunction

   function automatic void build_track();
      int          n_ev;
      int          r;
      logic [7:0]  last_st;
      logic [7:0]  st;
      logic [3:0]  cls;
      logic [27:0] dv;
      n_ev    = $urandom_range(1, 10);
      last_st = 8'd0;
      for (int i = 0; i < n_ev; i++) begin
         r = $urandom_range(0, 99);
         if (r < 50) dv = 28'd0;
         else if (r < 80) dv = 28'($urandom_range(1, 127));
         else if (r < 95) dv = 28'($urandom_range(128, 16383));
         else if (r < 98) dv = 28'($urandom_range(0, 28'hFFFFFFF));
         else dv = 28'hFFFFFFF;
         put_vlq(dv);
         r = $urandom_range(0, 99);
         if (r < 55) begin
            case ($urandom_range(0, 8))
               0:       cls = CLS_OFF;
               1, 2, 3: cls = CLS_ON;
               4:       cls = CLS_TOUCH;
               5:       cls = CLS_CTRL;
               6:       cls = CLS_PROG;
               7:       cls = CLS_PRESS;
               default: cls = CLS_BEND;
            endcase
            st = {cls, 4'($urandom_range(0, 15))};
            if (last_st != 8'd0 && $urandom_range(0, 2) == 0) st = last_st;
            else trk.push_back(st);
            last_st = st;
            trk.push_back(data_byte());
            if (st[7:4] != CLS_PROG && st[7:4] != CLS_PRESS)
               trk.push_back(($urandom_range(0, 4) == 0) ? 8'd0 : data_byte());
         end else begin
            last_st = 8'd0;
            if (r < 67) begin
               put_meta(META_TEMPO, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 5) : 3);
            end else if (r < 75) begin
               put_meta(8'($urandom_range(0, 255)), $urandom_range(0, 5));
            end else if (r < 80) begin
               put_meta(META_END, $urandom_range(0, 2));
            end else begin
               trk.push_back($urandom_range(0, 1) ? ST_SYSEX : ST_ESCAPE);
               r = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
               put_vlq(28'(r));
               put_body(r);
            end
         end
      end
      if ($urandom_range(0, 9) < 6) begin
         trk.push_back(8'h00);
         put_meta(META_END, 0);
      end
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_channel_messages();
      // note on, running-status note on with zero velocity, two-byte delta into a
      // control change with a high-bit data byte, program change on the final byte
      trk = '{8'h00, 8'h90, 8'h3C, 8'h64,
              8'h00, 8'h3C, 8'h00,
              8'h81, 8'h00, 8'hB2, 8'h07, 8'hFF,
              8'h00, 8'hC5, 8'h7F};
      send_chunk();
   endtask

   task automatic test_meta_events();
      // tempo, then an explicit end of track that completes on the final byte
      trk = '{8'h00, 8'hFF, 8'h51, 8'h03, 8'h07, 8'hA1, 8'h20,
              8'h00, 8'hFF, 8'h2F, 8'h00};
      send_chunk();
   endtask

   task automatic test_error_cases();
      trk = '{8'h00, 8'h3C};                       // data byte with no status held
      send_chunk();
      trk = '{8'h00, 8'hF4};                       // undefined system status
      send_chunk();
      trk = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};  // delta too long, then ignored byte
      send_chunk();
      trk = '{8'h81};                              // chunk ends inside a delta
      send_chunk();
   endtask

   task automatic test_tick_saturation();
      // maximal deltas overrun the tick range after sixteen events
      for (int i = 0; i < 18; i++) begin
         trk.push_back(8'hFF);
         trk.push_back(8'hFF);
         trk.push_back(8'hFF);
         trk.push_back(8'h7F);
         if (i == 0) trk.push_back(8'h93);
         trk.push_back(8'h40);
         trk.push_back(8'(8'h10 + i));
      end
      trk.push_back(8'h05);
      put_meta(META_END, 0);
      send_chunk();
   endtask

   task automatic test_random_tracks();
      int target;
      int r;
      int tracks;
      target = live_bytes + RANDOM_BYTES;
      tracks = 0;
      while (live_bytes < target) begin
         quiet = ($urandom_range(0, 4) == 0);
         build_track();
         r = $urandom_range(0, 99);
         if (r < 6) begin
            trk.delete();
            repeat ($urandom_range(1, 8)) trk.push_back(8'($urandom_range(0, 255)));
         end else if (r < 11) begin
            if (trk.size() > 1)
               repeat ($urandom_range(1, (trk.size() > 3) ? 3 : trk.size() - 1))
                  void'(trk.pop_back());
         end else if (r < 14) begin
            trk[$urandom_range(0, trk.size() - 1)] = 8'($urandom_range(0, 255));
         end else if (r < 16) begin
            repeat (4) trk.push_front({1'b1, 7'($urandom_range(0, 127))});
         end else if (r < 18) begin
            trk.push_front(8'($urandom_range(8'hF1, 8'hFE)));
            trk.push_front(8'h00);
         end else if (r < 20) begin
            trk.push_front(8'($urandom_range(0, 127)));
            trk.push_front(8'h00);
         end
         send_chunk();
         tracks++;
         if (tracks % 8 == 0) drain_events();
      end
      quiet = 1'b0;
   endtask

   // ---------------------------------------------------------------- response side

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (!quiet && $urandom_range(0, 99) < 20) begin
         stall_left = pick_gap();
         rsp_tready <= (stall_left == 0);
         if (stall_left != 0) stall_left = stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      string      bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind    = kind_type'(rsp_tuser);
         got.channel = rsp_tdata[3:0];
         got.d1      = rsp_tdata[11:4];
         got.d2      = rsp_tdata[19:12];
         got.tempo   = rsp_tdata[43:20];
         got.tick    = rsp_tdata[75:44];
         got.run_end = rsp_tlast;
         if (expected_events.size() == 0) begin
            faults++;
            if (shown < 10) begin
               shown++;
               $display("unexpected event: kind %0d ch %0d tick %0d", got.kind,
                        got.channel, got.tick);
            end
         end else begin
            want = expected_events.pop_front();
            kind_count[want.kind]++;
            bad = "";
            if (got.kind !== want.kind) bad = {bad, " kind"};
            if (got.channel !== want.channel) bad = {bad, " channel"};
            if (got.d1 !== want.d1) bad = {bad, " first_data"};
            if (got.d2 !== want.d2) bad = {bad, " second_data"};
            if (got.tempo !== want.tempo) bad = {bad, " tempo"};
            if (got.tick !== want.tick) bad = {bad, " tick"};
            if (got.run_end !== want.run_end) bad = {bad, " run_end"};
            if (rsp_tdata[79:76] !== 4'd0) bad = {bad, " padding"};
            if (bad != "") begin
               faults++;
               if (shown < 10) begin
                  shown++;
                  $display("mismatch in%s", bad);
                  $display("  expected kind %0d ch %0d d1 %h d2 %h tempo %h tick %h last %b",
                           want.kind, want.channel, want.d1, want.d2, want.tempo,
                           want.tick, want.run_end);
                  $display("  actual   kind %0d ch %0d d1 %h d2 %h tempo %h tick %h last %b",
                           got.kind, got.channel, got.d1, got.d2, got.tempo,
                           got.tick, got.run_end);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   initial begin
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
      end
      $display("no transaction for %0d cycles, %0d events outstanding", STALL_LIMIT,
               expected_events.size());
      $display("midi_track_event_parser regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      clear_parser();
      foreach (kind_count[k]) kind_count[k] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_channel_messages();
      test_meta_events();
      test_error_cases();
      drain_events();
      test_tick_saturation();
      test_random_tracks();

      drain_events();
      repeat (SETTLE) @(posedge clock);
      if (expected_events.size() != 0) begin
         faults += expected_events.size();
         $display("%0d predicted events never appeared", expected_events.size());
      end
      $display("%0d chunks, %0d bytes (%0d decoded), %0d mismatches", chunks_sent,
               bytes_sent, live_bytes, faults);
      $display("events: on %0d off %0d ctrl %0d prog %0d tempo %0d end %0d error %0d",
               kind_count[KIND_ON], kind_count[KIND_OFF], kind_count[KIND_CTRL],
               kind_count[KIND_PROG], kind_count[KIND_TEMPO], kind_count[KIND_END],
               kind_count[KIND_ERROR]);
      if (faults == 0) begin
         $display("midi_track_event_parser regression: pass");
      end else begin
         $display("midi_track_event_parser regression: fail");
      end
      $finish;
   end

endmodule
